>>> rtl/b32cpc_pkg.sv
// ----------------------------------------------------------------------------
// b32cpc_pkg
// Shared types, tables and helpers for the base32 code parser and checker.
// ----------------------------------------------------------------------------
package b32cpc_pkg;

    localparam int unsigned IdW      = 60;
    localparam int unsigned IdSyms   = 12;
    localparam int unsigned CountSat = 13;
    localparam int unsigned LeadLen  = 5;
    localparam logic [7:0]  DashChar = 8'h2D;

    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_BAD_CHAR = 2'd1,
        ERR_COUNT    = 2'd2,
        ERR_CHECK    = 2'd3
    } err_kind_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_DECIDE, ST_FLUSH, ST_CHECK, ST_LOAD, ST_ROUND, ST_FIN
    } state_t;

    typedef struct packed {
        logic       load_in;
        logic       take_hold;
        logic       take_lead;
        logic [2:0] lead_idx;
        logic       hash_init;
        logic       hash_round;
        logic       finish;
    } cmd_t;

    typedef struct packed {
        logic lead_match;
        logic hold_last;
        logic need_hash;
        logic round_last;
        logic out_full;
    } status_t;

    typedef struct packed {
        logic       skip;
        logic       valid;
        logic [4:0] value;
    } sym_t;

    function automatic logic [7:0] lead_byte(input logic [2:0] idx);
        case (idx)
            3'd0:    return 8'h6F;
            3'd1:    return 8'h70;
            3'd2:    return 8'h61;
            3'd3:    return 8'h6C;
            3'd4:    return 8'h3A;
            default: return 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] tag_byte(input logic [3:0] idx);
        case (idx)
            4'd0:    return 8'h4F;
            4'd1:    return 8'h50;
            4'd2:    return 8'h41;
            4'd3:    return 8'h4C;
            4'd4:    return 8'h2D;
            4'd5:    return 8'h49;
            4'd6:    return 8'h44;
            4'd7:    return 8'h2D;
            4'd8:    return 8'h76;
            4'd9:    return 8'h31;
            4'd10:   return 8'h0A;
            default: return 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] sym_char(input logic [4:0] v);
        logic [7:0] c;
        case (v) inside
            [5'd0:5'd9]:   c = 8'h30 + {3'd0, v};
            [5'd10:5'd17]: c = 8'h37 + {3'd0, v};
            [5'd18:5'd19]: c = 8'h38 + {3'd0, v};
            [5'd20:5'd21]: c = 8'h39 + {3'd0, v};
            [5'd22:5'd26]: c = 8'h3A + {3'd0, v};
            default:       c = 8'h3B + {3'd0, v};
        endcase
        return c;
    endfunction

    function automatic sym_t decode_char(input logic [7:0] raw);
        logic [7:0] b;
        sym_t       r;
        b = raw;
        r = '0;
        if (b >= 8'h61 && b <= 8'h7A) b = b - 8'h20;
        if (b == 8'h4F) b = 8'h30;
        else if (b == 8'h49 || b == 8'h4C) b = 8'h31;
        r.valid = 1'b1;
        case (b) inside
            DashChar:      r.skip  = 1'b1;
            [8'h30:8'h39]: r.value = 5'(b - 8'h30);
            [8'h41:8'h48]: r.value = 5'(b - 8'h37);
            [8'h4A:8'h4B]: r.value = 5'(b - 8'h38);
            [8'h4D:8'h4E]: r.value = 5'(b - 8'h39);
            [8'h50:8'h54]: r.value = 5'(b - 8'h3A);
            [8'h56:8'h5A]: r.value = 5'(b - 8'h3B);
            default:       r.valid = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic [31:0] h_init(input logic [2:0] idx);
        case (idx)
            3'd0:    return 32'h6a09e667;
            3'd1:    return 32'hbb67ae85;
            3'd2:    return 32'h3c6ef372;
            3'd3:    return 32'ha54ff53a;
            3'd4:    return 32'h510e527f;
            3'd5:    return 32'h9b05688c;
            3'd6:    return 32'h1f83d9ab;
            default: return 32'h5be0cd19;
        endcase
    endfunction

    function automatic logic [31:0] round_k(input logic [5:0] idx);
        logic [31:0] k [64];
        k = '{
            32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,
            32'h3956c25b,32'h59f111f1,32'h923f82a4,32'hab1c5ed5,
            32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
            32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,
            32'he49b69c1,32'hefbe4786,32'h0fc19dc6,32'h240ca1cc,
            32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
            32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,
            32'hc6e00bf3,32'hd5a79147,32'h06ca6351,32'h14292967,
            32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
            32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,
            32'ha2bfe8a1,32'ha81a664b,32'hc24b8b70,32'hc76c51a3,
            32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
            32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,
            32'h391c0cb3,32'h4ed8aa4a,32'h5b9cca4f,32'h682e6ff3,
            32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
            32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};
        return k[idx];
    endfunction

endpackage

>>> rtl/base32_code_parse_and_check.sv
// ----------------------------------------------------------------------------
// base32_code_parse_and_check
// Streams a typed code byte by byte, checks it as a 12-symbol base32 id.
// ----------------------------------------------------------------------------
// Sequence: each ordinary byte is held, then decoded; a byte that ends
//   or abandons the prefix also flushes the prefix bytes taken so far (up to 4) first.
// Final byte: decode, a check step, the hash (one load, then 64 rounds of the
//   single round unit) and a result step; invalid codes skip the hash.
// Throughput: one transaction at a time; a final byte waits for the result slot.
// Reset: rst_n asynchronous active low clears parse state and result valid.
module base32_code_parse_and_check (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] code_byte
    input  logic        s_tlast,   // final_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata    // [0] code_ok, [2:1] error_kind, [62:3] id_symbols
);
    import b32cpc_pkg::*;

    cmd_t    cmd;
    status_t status;

    // controller: prefix state machine and hash sequencing
    b32cpc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_last  (s_tlast),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath: symbol decode, hash round unit and result register
    b32cpc_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_byte   (s_tdata),
        .in_last   (s_tlast),
        .cmd       (cmd),
        .status    (status),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

endmodule

>>> rtl/b32cpc_dp.sv
// ----------------------------------------------------------------------------
// b32cpc_dp
// Datapath: input hold, symbol decode and shift, hash rounds, result register.
// ----------------------------------------------------------------------------
module b32cpc_dp (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [7:0]         in_byte,
    input  logic               in_last,
    input  b32cpc_pkg::cmd_t   cmd,
    output b32cpc_pkg::status_t status,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [63:0]        out_data
);
    import b32cpc_pkg::*;

    logic [7:0]  hold_reg;
    logic        last_reg;
    logic [3:0]  count_reg,  count_next;
    logic [59:0] shift_reg,  shift_next;
    logic        bad_reg,    bad_next;
    logic [5:0]  round_reg;
    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg, f_reg, g_reg, h_reg;
    logic [31:0] w_reg [16];
    logic        out_valid_reg;
    logic        ok_reg;
    logic [1:0]  err_reg;
    logic [59:0] id_reg;

    sym_t        sym;
    logic [7:0]  take_byte;
    logic        take;
    logic [511:0] blk;
    logic [31:0] s0, s1, w_new, t1, t2, ep, ap;
    logic [9:0]  top_bits;
    err_kind_t   err;

    assign take      = cmd.take_hold | cmd.take_lead;
    assign take_byte = cmd.take_lead ? lead_byte(cmd.lead_idx) : hold_reg;
    assign sym       = decode_char(take_byte);

    always_comb
    begin
        count_next = count_reg;
        shift_next = shift_reg;
        bad_next   = bad_reg;
        if (take && !sym.skip)
        begin
            if (!sym.valid)
                bad_next = 1'b1;
            else
            begin
                if (count_reg < 4'(CountSat)) count_next = count_reg + 4'd1;
                shift_next = {shift_reg[54:0], sym.value};
            end
        end
    end

    // padded single message block
    always_comb
    begin
        blk = '0;
        for (int i = 0; i < 11; i++)
            blk[511 - 8*i -: 8] = tag_byte(4'(i));
        for (int i = 0; i < 10; i++)
            blk[511 - 8*(11+i) -: 8] = sym_char(shift_reg[59 - 5*i -: 5]);
        blk[511 - 8*21 -: 8] = 8'h80;
        blk[7:0]             = 8'hA8;
    end

    assign s0    = {w_reg[1][6:0], w_reg[1][31:7]} ^ {w_reg[1][17:0], w_reg[1][31:18]}
                 ^ (w_reg[1] >> 3);
    assign s1    = {w_reg[14][16:0], w_reg[14][31:17]} ^ {w_reg[14][18:0], w_reg[14][31:19]}
                 ^ (w_reg[14] >> 10);
    assign w_new = w_reg[0] + s0 + w_reg[9] + s1;
    assign ep    = {e_reg[5:0], e_reg[31:6]} ^ {e_reg[10:0], e_reg[31:11]}
                 ^ {e_reg[24:0], e_reg[31:25]};
    assign ap    = {a_reg[1:0], a_reg[31:2]} ^ {a_reg[12:0], a_reg[31:13]}
                 ^ {a_reg[21:0], a_reg[31:22]};
    assign t1    = h_reg + ep + ((e_reg & f_reg) ^ (~e_reg & g_reg)) + round_k(round_reg)
                 + w_reg[0];
    assign t2    = ap + ((a_reg & b_reg) ^ (a_reg & c_reg) ^ (b_reg & c_reg));

    logic [31:0] hw0;
    assign hw0      = a_reg + h_init(3'd0);
    assign top_bits = hw0[31:22];

    always_comb
    begin
        if (bad_reg)                       err = ERR_BAD_CHAR;
        else if (count_reg != 4'(IdSyms))  err = ERR_COUNT;
        else if (top_bits != shift_reg[9:0]) err = ERR_CHECK;
        else                               err = ERR_NONE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            shift_reg     <= '0;
            bad_reg       <= 1'b0;
            round_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.finish)
            begin
                count_reg <= '0;
                shift_reg <= '0;
                bad_reg   <= 1'b0;
            end
            else
            begin
                count_reg <= count_next;
                shift_reg <= shift_next;
                bad_reg   <= bad_next;
            end
            if (cmd.hash_init)       round_reg <= '0;
            else if (cmd.hash_round) round_reg <= round_reg + 6'd1;
            if (cmd.finish)          out_valid_reg <= 1'b1;
            else if (out_ready)      out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            hold_reg <= in_byte;
            last_reg <= in_last;
        end
        if (cmd.hash_init)
        begin
            a_reg <= h_init(3'd0); b_reg <= h_init(3'd1);
            c_reg <= h_init(3'd2); d_reg <= h_init(3'd3);
            e_reg <= h_init(3'd4); f_reg <= h_init(3'd5);
            g_reg <= h_init(3'd6); h_reg <= h_init(3'd7);
            for (int i = 0; i < 16; i++)
                w_reg[i] <= blk[511 - 32*i -: 32];
        end
        else if (cmd.hash_round)
        begin
            h_reg <= g_reg; g_reg <= f_reg; f_reg <= e_reg; e_reg <= d_reg + t1;
            d_reg <= c_reg; c_reg <= b_reg; b_reg <= a_reg; a_reg <= t1 + t2;
            for (int i = 0; i < 15; i++)
                w_reg[i] <= w_reg[i+1];
            w_reg[15] <= w_new;
        end
        if (cmd.finish)
        begin
            ok_reg  <= (err == ERR_NONE);
            err_reg <= err;
            id_reg  <= (err == ERR_NONE) ? shift_reg : '0;
        end
    end

    assign status.lead_match = (hold_reg == lead_byte(cmd.lead_idx));
    assign status.hold_last  = last_reg;
    assign status.need_hash  = !bad_reg && (count_reg == 4'(IdSyms));
    assign status.round_last = (round_reg == 6'd63);
    assign status.out_full   = out_valid_reg;

    assign out_valid = out_valid_reg;
    assign out_data  = {1'b0, id_reg, err_reg, ok_reg};

endmodule

>>> rtl/b32cpc_ctrl.sv
// ----------------------------------------------------------------------------
// b32cpc_ctrl
// Controller: prefix tracking, prefix flush sequencing and hash sequencing.
// ----------------------------------------------------------------------------
module b32cpc_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_last,
    output logic                in_ready,
    input  b32cpc_pkg::status_t status,
    output b32cpc_pkg::cmd_t    cmd
);
    import b32cpc_pkg::*;

    state_t     state_reg, state_next;
    logic [2:0] prog_reg,  prog_next;
    logic [2:0] n_reg,     n_next;
    logic [2:0] k_reg,     k_next;
    logic       th_reg,    th_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            prog_reg  <= '0;
            n_reg     <= '0;
            k_reg     <= '0;
            th_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            prog_reg  <= prog_next;
            n_reg     <= n_next;
            k_reg     <= k_next;
            th_reg    <= th_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        prog_next  = prog_reg;
        n_next     = n_reg;
        k_next     = k_reg;
        th_next    = th_reg;
        cmd        = '0;
        cmd.lead_idx = prog_reg;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                // a final byte waits until the result slot is free
                in_ready = !in_last || !status.out_full;
                if (in_valid && in_ready)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                k_next = '0;
                if (prog_reg >= 3'(LeadLen))
                begin
                    cmd.take_hold = 1'b1;
                    state_next    = status.hold_last ? ST_CHECK : ST_IDLE;
                end
                else if (status.lead_match)
                begin
                    prog_next = prog_reg + 3'd1;
                    n_next    = prog_reg + 3'd1;
                    th_next   = 1'b0;
                    if (!status.hold_last)
                        state_next = ST_IDLE;
                    else if (prog_reg + 3'd1 < 3'(LeadLen))
                        state_next = ST_FLUSH;
                    else
                        state_next = ST_CHECK;
                end
                else
                begin
                    prog_next  = 3'd6;
                    n_next     = prog_reg;
                    th_next    = 1'b1;
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                cmd.lead_idx = k_reg;
                if (k_reg < n_reg)
                begin
                    cmd.take_lead = 1'b1;
                    k_next        = k_reg + 3'd1;
                end
                else
                begin
                    cmd.take_hold = th_reg;
                    state_next    = status.hold_last ? ST_CHECK : ST_IDLE;
                end
            end
            ST_CHECK:
                state_next = status.need_hash ? ST_LOAD : ST_FIN;
            ST_LOAD:
            begin
                cmd.hash_init = 1'b1;
                state_next    = ST_ROUND;
            end
            ST_ROUND:
            begin
                cmd.hash_round = 1'b1;
                if (status.round_last) state_next = ST_FIN;
            end
            ST_FIN:
            begin
                cmd.finish = 1'b1;
                prog_next  = '0;
                state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

endmodule

>>> rtl/b32cpc_checker.sv
// ----------------------------------------------------------------------------
// b32cpc_checker
// Port-level assertions for the base32 code parser and checker.
// ----------------------------------------------------------------------------
module b32cpc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_ok_err: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[0] == (m_tdata[2:1] == 2'd0)))
        else $error("code_ok disagrees with error_kind");

    a_id_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[0] |-> (m_tdata[62:3] == 60'd0))
        else $error("id not zero on invalid code");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("input taken during check");
endmodule

bind base32_code_parse_and_check b32cpc_checker u_chk (
    .clk(clk), .rst_n(rst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .s_tlast(s_tlast), .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
